>>> hdl/ias_pkg.sv
// Shared constants, types and command struct for the indexed array block.
package ias_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 2;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_ERASE  = 2'd1,
		MODE_SORT   = 2'd2
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_FULL      = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ERASE,
		CELL_SORT
	} cell_op_t;

	typedef enum logic {
		CTRL_IDLE,
		CTRL_SORT
	} ctrl_state_t;

	// Command broadcast from the controller to every cell in the row
	typedef struct packed {
		cell_op_t           op;
		logic [ADDR_W-1:0]  pos;
		logic [DATA_W-1:0]  value;
		logic               ascending;
		logic               parity;
		logic [CNT_W-1:0]   count;
	} cell_cmd_t;

endpackage

>>> hdl/ias_cell.sv
// One storage cell of the array row: shift, load or compare-exchange with a neighbor.
module ias_cell (
	input  logic                         clk,
	input  logic [ias_pkg::ADDR_W-1:0]   slot,
	input  ias_pkg::cell_cmd_t           cmd,
	input  ias_pkg::word_t               left,
	input  ias_pkg::word_t               right,
	output ias_pkg::word_t               data
);

	ias_pkg::word_t data_q;
	ias_pkg::word_t data_d;
	logic           lower;
	logic           upper;
	logic           swap_lo;
	logic           swap_hi;

	// Decide this cell's role in the current transposition phase
	always_comb begin
		lower = (slot[0] == cmd.parity) &&
			((ias_pkg::CNT_W'(slot) + ias_pkg::CNT_W'(1)) < cmd.count);
		upper = (slot != '0) && (slot[0] != cmd.parity) &&
			(ias_pkg::CNT_W'(slot) < cmd.count);
		swap_lo = cmd.ascending ? (data_q > right) : (data_q < right);
		swap_hi = cmd.ascending ? (left > data_q) : (left < data_q);
	end

	// Select next contents from the broadcast command
	always_comb begin
		data_d = data_q;
		case (cmd.op)
			ias_pkg::CELL_INSERT: begin
				if (slot > cmd.pos) begin
					data_d = left;
				end else if (slot == cmd.pos) begin
					data_d = $signed(cmd.value);
				end
			end
			ias_pkg::CELL_ERASE: begin
				if (slot >= cmd.pos) begin
					data_d = right;
				end
			end
			ias_pkg::CELL_SORT: begin
				if (lower && swap_lo) begin
					data_d = right;
				end else if (upper && swap_hi) begin
					data_d = left;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

>>> hdl/ias_ctrl.sv
// Request decoder, sort sequencer, entry count and result register.
module ias_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ias_pkg::MODE_W-1:0]   mode,
	input  logic [ias_pkg::CNT_W-1:0]    index,
	input  ias_pkg::word_t               value,
	input  logic                         ascending,
	input  ias_pkg::word_t               vals [ias_pkg::CAPACITY],
	output ias_pkg::cell_cmd_t           cmd,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ias_pkg::word_t               removed_value,
	output logic [ias_pkg::CNT_W-1:0]    count,
	output logic [ias_pkg::STAT_W-1:0]   status
);

	ias_pkg::ctrl_state_t            state_q;
	ias_pkg::ctrl_state_t            state_d;
	logic [ias_pkg::CNT_W-1:0]       count_q;
	logic [ias_pkg::CNT_W-1:0]       count_d;
	logic [ias_pkg::ADDR_W-1:0]      phase_q;
	logic                            asc_q;
	logic                            accept;
	logic                            load_out;
	logic                            last_phase;
	ias_pkg::word_t                  res_removed;
	ias_pkg::stat_t                  res_status;
	logic                            out_valid_q;
	ias_pkg::word_t                  removed_q;
	logic [ias_pkg::CNT_W-1:0]       count_out_q;
	ias_pkg::stat_t                  status_q;

	// Take a transaction only when idle and the result register can be refilled
	assign in_stall   = (state_q == ias_pkg::CTRL_SORT) || (out_valid_q && out_stall);
	assign accept     = in_valid && !in_stall;
	assign last_phase = (ias_pkg::CNT_W'(phase_q) == (count_q - ias_pkg::CNT_W'(1)));

	// Decode the request and sequence the sort phases
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		load_out      = 1'b0;
		res_removed   = '0;
		res_status    = ias_pkg::STAT_DONE;
		cmd.op        = ias_pkg::CELL_HOLD;
		cmd.pos       = index[ias_pkg::ADDR_W-1:0];
		cmd.value     = value;
		cmd.ascending = asc_q;
		cmd.parity    = phase_q[0];
		cmd.count     = count_q;
		case (state_q)
			ias_pkg::CTRL_IDLE: begin
				if (accept) begin
					case (ias_pkg::mode_t'(mode))
						ias_pkg::MODE_INSERT: begin
							load_out = 1'b1;
							if (index > count_q) begin
								res_status = ias_pkg::STAT_BAD_INDEX;
							end else if (count_q == ias_pkg::CNT_W'(ias_pkg::CAPACITY)) begin
								res_status = ias_pkg::STAT_FULL;
							end else begin
								cmd.op  = ias_pkg::CELL_INSERT;
								count_d = count_q + ias_pkg::CNT_W'(1);
							end
						end
						ias_pkg::MODE_ERASE: begin
							load_out = 1'b1;
							if (index >= count_q) begin
								res_status = ias_pkg::STAT_BAD_INDEX;
							end else begin
								cmd.op      = ias_pkg::CELL_ERASE;
								res_removed = vals[index[ias_pkg::ADDR_W-1:0]];
								count_d     = count_q - ias_pkg::CNT_W'(1);
							end
						end
						ias_pkg::MODE_SORT: begin
							if (count_q > ias_pkg::CNT_W'(1)) begin
								state_d = ias_pkg::CTRL_SORT;
							end else begin
								load_out = 1'b1;
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ias_pkg::CTRL_SORT: begin
				cmd.op = ias_pkg::CELL_SORT;
				if (last_phase) begin
					load_out = 1'b1;
					state_d  = ias_pkg::CTRL_IDLE;
				end
			end
			default: begin
				state_d = ias_pkg::CTRL_IDLE;
			end
		endcase
	end

	// Advance state, count, phase counter and sort direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ias_pkg::CTRL_IDLE;
			count_q <= '0;
			phase_q <= '0;
			asc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ias_pkg::CTRL_SORT) begin
				phase_q <= phase_q + ias_pkg::ADDR_W'(1);
			end else begin
				phase_q <= '0;
			end
			if (accept) begin
				asc_q <= ascending;
			end
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			removed_q   <= res_removed;
			count_out_q <= count_d;
			status_q    <= res_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign count         = count_out_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ias_pkg::CNT_W'(ias_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_sort_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ias_pkg::CTRL_SORT) |-> !out_valid_q)
		else $error("result pending during sort");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(accept))
		else $error("count changed without a transaction");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ias_pkg::CTRL_SORT) |-> (ias_pkg::CNT_W'(phase_q) < count_q))
		else $error("sort phase past entry count");
`endif

endmodule

>>> hdl/indexed_array_insert_erase_sort.sv
// Top level: indexed array with insert, erase and sort over a row of cells.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   in       | in_valid/in_stall  | mode, index, value, ascending
//   out      | out_valid/out_stall| removed_value, count, status
//
// Insert, erase, rejected requests and unused modes complete on acceptance:
// every cell shifts or loads on the same edge that loads the result register.
// Sort accepts the request, then runs one odd-even transposition phase per cycle
// across the row, count phases in all; input stalls during them.
// A sort of fewer than two entries completes on acceptance like an insert.
// Reset clears the entry count and the control; cell contents stay undefined.
// Input stalls while a sort runs or while a result waits under out_stall.
module indexed_array_insert_erase_sort (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ias_pkg::MODE_W-1:0]   mode,
	input  logic [ias_pkg::CNT_W-1:0]    index,
	input  logic signed [ias_pkg::DATA_W-1:0] value,
	input  logic                         ascending,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ias_pkg::DATA_W-1:0] removed_value,
	output logic [ias_pkg::CNT_W-1:0]    count,
	output logic [ias_pkg::STAT_W-1:0]   status
);

	ias_pkg::cell_cmd_t cmd;
	ias_pkg::word_t     cell_data [ias_pkg::CAPACITY];

	// Decode requests and sequence the row
	ias_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.index         (index),
		.value         (value),
		.ascending     (ascending),
		.vals          (cell_data),
		.cmd           (cmd),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.removed_value (removed_value),
		.count         (count),
		.status        (status)
	);

	// Build the row of cells, each wired to its neighbors
	for (genvar g = 0; g < ias_pkg::CAPACITY; g++) begin : g_cell
		ias_pkg::word_t left_w;
		ias_pkg::word_t right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end

		if (g == ias_pkg::CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		ias_cell u_cell (
			.clk   (clk),
			.slot  (ias_pkg::ADDR_W'(g)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[g])
		);
	end

endmodule
